// ===== rtl/pam_pkg.sv =====
package pam_pkg;

  // field widths fixed by the item formats
  localparam int CFG_W  = 7;
  localparam int SLOT_W = 6;
  localparam int PLEN_W = 8;
  localparam int ADDR_W = 64;

  // transaction modes
  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  // address families
  localparam logic FAM_IPV4 = 1'b0;
  localparam logic FAM_IPV6 = 1'b1;

  // rule kinds as stored in the table
  localparam logic [1:0] KIND_EMPTY  = 2'd0;
  localparam logic [1:0] KIND_HOST   = 2'd1;
  localparam logic [1:0] KIND_PREFIX = 2'd2;
  localparam logic [1:0] KIND_ANY    = 2'd3;

  // match classes, lower is better; none means nothing matched yet
  localparam logic [1:0] CLS_HOST   = 2'd0;
  localparam logic [1:0] CLS_PREFIX = 2'd1;
  localparam logic [1:0] CLS_ANY    = 2'd2;
  localparam logic [1:0] CLS_NONE   = 2'd3;

  // longest legal prefix per family
  localparam logic [PLEN_W-1:0] PLEN_MAX_V4 = 8'd32;
  localparam logic [PLEN_W-1:0] PLEN_MAX_V6 = 8'd128;

  typedef struct packed {
    logic                  mode;
    logic [SLOT_W-1:0]     rule_slot;
    logic [1:0]            rule_kind;
    logic                  family;
    logic [PLEN_W-1:0]     prefix_length;
    logic [ADDR_W-1:0]     address_high;
    logic [ADDR_W-1:0]     address_low;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] matched_slot;
    logic [1:0]        matched_class;
  } out_item_t;

  // 11-bit table entry: kind in 1..0, family in 2, prefix in 10..3
  typedef struct packed {
    logic [PLEN_W-1:0] plen;
    logic              family;
    logic [1:0]        kind;
  } rule_info_t;

  typedef struct packed {
    logic [ADDR_W-1:0] hi;
    logic [ADDR_W-1:0] lo;
  } rule_addr_t;

  // write strobes and data towards the rule memories
  typedef struct packed {
    logic       info_we;
    logic       addr_we;
    rule_info_t info;
    rule_addr_t addr;
  } rule_wr_t;

  // registered read data back from the rule memories
  typedef struct packed {
    logic       valid;
    rule_info_t info;
    rule_addr_t addr;
  } rule_rd_t;

  // peer under lookup, already normalised to its family
  typedef struct packed {
    logic       family;
    rule_addr_t addr;
  } peer_t;

  // best candidate so far
  typedef struct packed {
    logic [1:0]        cls;
    logic [SLOT_W-1:0] slot;
  } best_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

endpackage

// ===== rtl/priority_address_rule_matcher_top.sv =====
// rule write: no result transaction
// lookup: entries 0 .. min(rule_count, MAX_RULES) - 1 are scanned, one table entry read
//   per cycle from the rule memory; next item taken once the result is loaded
// a finished result waits in the output register while the next item is taken
// after reset the rule table is swept to empty, input stalled meanwhile;
//   rule_count resets to 0, configuration always ready
module priority_address_rule_matcher_top #(
  parameter int MAX_RULES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  pam_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output pam_pkg::out_item_t            out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pam_pkg::CFG_W-1:0]     cfg_data_i
);

  localparam int IDX_W  = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CNT_W0 = $clog2(MAX_RULES + 1);
  localparam int LIM_W  = (CNT_W0 > pam_pkg::CFG_W) ? CNT_W0 : pam_pkg::CFG_W;

  pam_pkg::state_e          state_q, state_d;
  logic [IDX_W-1:0]         clr_q, clr_d;
  logic [LIM_W-1:0]         scan_q, scan_d;
  logic [LIM_W-1:0]         limit_q, limit_d;
  logic [pam_pkg::CFG_W-1:0] rule_count_q;
  pam_pkg::peer_t           peer_q, peer_d;
  logic                     out_valid_q;
  pam_pkg::out_item_t       out_data_q, out_data_d;

  logic                     accept;
  logic                     lookup_acc;
  logic                     write_acc;
  logic                     slot_ok;
  logic                     out_free;
  logic                     in_stall;
  logic                     rd_en;
  logic                     clr_en;
  logic                     out_load;
  logic [LIM_W-1:0]         cnt_ext;
  logic [LIM_W-1:0]         max_ext;
  pam_pkg::rule_addr_t      in_addr;
  pam_pkg::rule_info_t      new_info;
  pam_pkg::rule_wr_t        wr;
  logic [IDX_W-1:0]         waddr;
  pam_pkg::rule_rd_t        rd;
  logic [IDX_W-1:0]         ridx;
  pam_pkg::best_t           best;

  // input transaction decode
  assign accept     = in_valid_i && !in_stall;
  assign lookup_acc = accept && (in_data_i.mode == pam_pkg::MODE_LOOKUP);
  assign write_acc  = accept && (in_data_i.mode == pam_pkg::MODE_WRITE);
  assign slot_ok    = (32'(in_data_i.rule_slot) < 32'(MAX_RULES));
  assign out_free   = !out_valid_q || !out_stall_i;

  // address normalised to its family, ipv4 lives in the low 32 bits
  always_comb begin
    in_addr.hi = in_data_i.address_high;
    in_addr.lo = in_data_i.address_low;
    if (in_data_i.family == pam_pkg::FAM_IPV4) begin
      in_addr.hi = '0;
      in_addr.lo = {32'b0, in_data_i.address_low[31:0]};
    end
  end

  // rule entry, a prefix too long for its family is stored empty
  always_comb begin
    new_info.kind   = in_data_i.rule_kind;
    new_info.family = in_data_i.family;
    new_info.plen   = in_data_i.prefix_length;
    if (in_data_i.rule_kind == pam_pkg::KIND_PREFIX) begin
      if (in_data_i.family == pam_pkg::FAM_IPV6) begin
        if (in_data_i.prefix_length > pam_pkg::PLEN_MAX_V6) begin
          new_info.kind = pam_pkg::KIND_EMPTY;
        end
      end else if (in_data_i.prefix_length > pam_pkg::PLEN_MAX_V4) begin
        new_info.kind = pam_pkg::KIND_EMPTY;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pam_pkg::ST_CLEAR: begin
        if (clr_q == IDX_W'(MAX_RULES - 1)) state_d = pam_pkg::ST_IDLE;
      end
      pam_pkg::ST_IDLE: begin
        if (lookup_acc) state_d = pam_pkg::ST_SCAN;
      end
      pam_pkg::ST_SCAN: begin
        if (scan_q == limit_q) state_d = pam_pkg::ST_DRAIN;
      end
      pam_pkg::ST_DRAIN: begin
        state_d = pam_pkg::ST_FINISH;
      end
      pam_pkg::ST_FINISH: begin
        if (out_free) state_d = pam_pkg::ST_IDLE;
      end
      default: state_d = pam_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall = 1'b1;
    rd_en    = 1'b0;
    clr_en   = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      pam_pkg::ST_CLEAR:  clr_en   = 1'b1;
      pam_pkg::ST_IDLE:   in_stall = 1'b0;
      pam_pkg::ST_SCAN:   rd_en    = (scan_q != limit_q);
      pam_pkg::ST_DRAIN:  ;
      pam_pkg::ST_FINISH: out_load = out_free;
      default:            ;
    endcase
  end

  // memory write port: clearing sweep or rule write
  always_comb begin
    wr.info_we = 1'b0;
    wr.addr_we = 1'b0;
    wr.info    = new_info;
    wr.addr    = in_addr;
    waddr      = IDX_W'(in_data_i.rule_slot);
    if (clr_en) begin
      wr.info_we     = 1'b1;
      wr.info.kind   = pam_pkg::KIND_EMPTY;
      wr.info.family = pam_pkg::FAM_IPV4;
      wr.info.plen   = '0;
      waddr          = clr_q;
    end else if (write_acc && slot_ok) begin
      wr.info_we = 1'b1;
      wr.addr_we = 1'b1;
    end
  end

  // scan bound, rule_count capped at the table depth
  always_comb begin
    cnt_ext = LIM_W'(rule_count_q);
    max_ext = LIM_W'(MAX_RULES);
    limit_d = limit_q;
    peer_d  = peer_q;
    if (lookup_acc) begin
      limit_d       = (cnt_ext > max_ext) ? max_ext : cnt_ext;
      peer_d.family = in_data_i.family;
      peer_d.addr   = in_addr;
    end
  end

  // counters
  always_comb begin
    clr_d  = clr_en ? IDX_W'(clr_q + 1'b1) : clr_q;
    scan_d = scan_q;
    if (lookup_acc) begin
      scan_d = '0;
    end else if (rd_en) begin
      scan_d = LIM_W'(scan_q + 1'b1);
    end
  end

  // result formatting, slot and class read zero when nothing matched
  always_comb begin
    out_data_d.found         = (best.cls != pam_pkg::CLS_NONE);
    out_data_d.matched_slot  = out_data_d.found ? best.slot : '0;
    out_data_d.matched_class = out_data_d.found ? best.cls : pam_pkg::CLS_HOST;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= pam_pkg::ST_CLEAR;
      clr_q        <= '0;
      scan_q       <= '0;
      rule_count_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      scan_q  <= scan_d;
      if (cfg_valid_i) begin
        rule_count_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    limit_q <= limit_d;
    peer_q  <= peer_d;
    if (out_load) begin
      out_data_q <= out_data_d;
    end
  end

  pam_rule_mem #(
    .MAX_RULES (MAX_RULES)
  ) u_rule_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .waddr_i (waddr),
    .re_i    (rd_en),
    .raddr_i (scan_q[IDX_W-1:0]),
    .rd_o    (rd),
    .ridx_o  (ridx)
  );

  pam_match_unit #(
    .MAX_RULES (MAX_RULES)
  ) u_match_unit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lookup_acc),
    .peer_i  (peer_q),
    .rd_i    (rd),
    .ridx_i  (ridx),
    .best_o  (best)
  );

  assign in_stall_o  = in_stall;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign cfg_ready_o = 1'b1;

endmodule

// ===== rtl/pam_rule_mem.sv =====
module pam_rule_mem #(
  parameter int MAX_RULES = 64
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  pam_pkg::rule_wr_t                          wr_i,
  input  logic [((MAX_RULES > 1) ? $clog2(MAX_RULES) : 1)-1:0] waddr_i,
  input  logic                                       re_i,
  input  logic [((MAX_RULES > 1) ? $clog2(MAX_RULES) : 1)-1:0] raddr_i,
  output pam_pkg::rule_rd_t                          rd_o,
  output logic [((MAX_RULES > 1) ? $clog2(MAX_RULES) : 1)-1:0] ridx_o
);

  localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;

  pam_pkg::rule_info_t info_mem [MAX_RULES];
  pam_pkg::rule_addr_t addr_mem [MAX_RULES];

  pam_pkg::rule_info_t info_rd_q;
  pam_pkg::rule_addr_t addr_rd_q;
  logic [IDX_W-1:0]    ridx_q;
  logic                rd_valid_q;

  // info table, cleared by the sweep after reset
  always_ff @(posedge clk_i) begin
    if (wr_i.info_we) begin
      info_mem[waddr_i] <= wr_i.info;
    end
    if (re_i) begin
      info_rd_q <= info_mem[raddr_i];
    end
  end

  // address table, never cleared
  always_ff @(posedge clk_i) begin
    if (wr_i.addr_we) begin
      addr_mem[waddr_i] <= wr_i.addr;
    end
    if (re_i) begin
      addr_rd_q <= addr_mem[raddr_i];
      ridx_q    <= raddr_i;
    end
  end

  // read data valid in the cycle after the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= re_i;
    end
  end

  assign rd_o.valid = rd_valid_q;
  assign rd_o.info  = info_rd_q;
  assign rd_o.addr  = addr_rd_q;
  assign ridx_o     = ridx_q;

endmodule

// ===== rtl/pam_match_unit.sv =====
module pam_match_unit #(
  parameter int MAX_RULES = 64
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       start_i,
  input  pam_pkg::peer_t                             peer_i,
  input  pam_pkg::rule_rd_t                          rd_i,
  input  logic [((MAX_RULES > 1) ? $clog2(MAX_RULES) : 1)-1:0] ridx_i,
  output pam_pkg::best_t                             best_o
);

  // per-bit prefix mask, top plen bits of the family's address width
  function automatic logic [2*pam_pkg::ADDR_W-1:0] prefix_mask(
    input logic                      fam,
    input logic [pam_pkg::PLEN_W-1:0] plen
  );
    logic [2*pam_pkg::ADDR_W-1:0] m;
    m = '0;
    for (int i = 0; i < 2 * pam_pkg::ADDR_W; i++) begin
      if (fam == pam_pkg::FAM_IPV6) begin
        m[2*pam_pkg::ADDR_W-1-i] = (8'(i) < plen);
      end else if (i < 32) begin
        m[31-i] = (8'(i) < plen);
      end
    end
    return m;
  endfunction

  logic [1:0]                   rule_cls;
  logic [2*pam_pkg::ADDR_W-1:0] diff;
  logic                         hit;
  logic                         take;
  pam_pkg::best_t               best_q;
  pam_pkg::best_t               best_d;

  // does the entry just read match the peer
  always_comb begin
    rule_cls = 2'(rd_i.info.kind - 2'd1);
    diff     = rd_i.addr ^ peer_i.addr;
    hit      = 1'b0;
    unique case (rd_i.info.kind)
      pam_pkg::KIND_EMPTY:  hit = 1'b0;
      pam_pkg::KIND_ANY:    hit = 1'b1;
      pam_pkg::KIND_HOST:   hit = (rd_i.info.family == peer_i.family) && (diff == '0);
      pam_pkg::KIND_PREFIX: hit = (rd_i.info.family == peer_i.family) &&
                                  ((diff & prefix_mask(peer_i.family, rd_i.info.plen)) == '0);
      default:              hit = 1'b0;
    endcase
    take = rd_i.valid && hit && (rule_cls < best_q.cls);
  end

  // keep the best class, first slot wins within a class
  always_comb begin
    best_d = best_q;
    if (start_i) begin
      best_d.cls  = pam_pkg::CLS_NONE;
      best_d.slot = '0;
    end else if (take) begin
      best_d.cls  = rule_cls;
      best_d.slot = pam_pkg::SLOT_W'(ridx_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q.cls  <= pam_pkg::CLS_NONE;
      best_q.slot <= '0;
    end else begin
      best_q <= best_d;
    end
  end

  assign best_o = best_q;

endmodule

// ===== dv/rule_match_checker.sv =====
`timescale 1ns / 1ps

module rule_match_checker #(
  parameter int MAX_RULES = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  pam_pkg::in_item_t         in_data_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  pam_pkg::out_item_t        out_data_i,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [pam_pkg::CFG_W-1:0] cfg_data_i,
  output int                        pending_o,
  output int                        errors_o
);

  // own copy of the rule table and the count register
  pam_pkg::rule_info_t        rule_tbl [MAX_RULES];
  logic [pam_pkg::ADDR_W-1:0] rule_hi  [MAX_RULES];
  logic [pam_pkg::ADDR_W-1:0] rule_lo  [MAX_RULES];
  logic [pam_pkg::CFG_W-1:0]  rule_count;

  // predicted lookup answers, oldest first
  pam_pkg::out_item_t expected_matches [$];

  int n_errors;
  int n_writes;
  int n_lookups;
  int n_cfg;
  int n_miss;
  int n_class [3];

  // does a stored prefix cover the peer address
  function automatic logic prefix_covers(
    input logic                       fam,
    input logic [pam_pkg::PLEN_W-1:0] plen,
    input logic [pam_pkg::ADDR_W-1:0] r_hi,
    input logic [pam_pkg::ADDR_W-1:0] r_lo,
    input logic [pam_pkg::ADDR_W-1:0] p_hi,
    input logic [pam_pkg::ADDR_W-1:0] p_lo
  );
    logic [31:0]  m32;
    logic [127:0] m128;
    if (fam == pam_pkg::FAM_IPV4) begin
      m32 = (plen == 0) ? 32'd0 : (32'hFFFF_FFFF << (32 - plen));
      return ((p_lo[31:0] ^ r_lo[31:0]) & m32) == 32'd0;
    end
    m128 = (plen == 0) ? 128'd0 : ({128{1'b1}} << (128 - plen));
    return (({p_hi, p_lo} ^ {r_hi, r_lo}) & m128) == 128'd0;
  endfunction

  // best class wins, first listed rule within a class
  function automatic pam_pkg::out_item_t best_rule_for_peer(
    input logic                       fam,
    input logic [pam_pkg::ADDR_W-1:0] p_hi,
    input logic [pam_pkg::ADDR_W-1:0] p_lo
  );
    pam_pkg::out_item_t         res;
    logic [1:0]                 best_cls;
    logic [pam_pkg::SLOT_W-1:0] best_slot;
    logic [1:0]                 cls;
    logic                       hit;
    int                         scan;
    scan      = (rule_count > MAX_RULES) ? MAX_RULES : int'(rule_count);
    best_cls  = pam_pkg::CLS_NONE;
    best_slot = '0;
    for (int i = 0; i < scan; i++) begin
      hit = 1'b0;
      case (rule_tbl[i].kind)
        pam_pkg::KIND_HOST:   cls = pam_pkg::CLS_HOST;
        pam_pkg::KIND_PREFIX: cls = pam_pkg::CLS_PREFIX;
        pam_pkg::KIND_ANY:    cls = pam_pkg::CLS_ANY;
        default:              cls = pam_pkg::CLS_NONE;
      endcase
      if (cls == pam_pkg::CLS_NONE || cls >= best_cls) continue;
      if (rule_tbl[i].kind == pam_pkg::KIND_ANY) begin
        hit = 1'b1;
      end else if (rule_tbl[i].family == fam) begin
        if (rule_tbl[i].kind == pam_pkg::KIND_HOST)
          hit = (rule_hi[i] == p_hi) && (rule_lo[i] == p_lo);
        else
          hit = prefix_covers(fam, rule_tbl[i].plen, rule_hi[i], rule_lo[i],
                              p_hi, p_lo);
      end
      if (hit) begin
        best_cls  = cls;
        best_slot = pam_pkg::SLOT_W'(i);
      end
    end
    res = '0;
    if (best_cls != pam_pkg::CLS_NONE) begin
      res.found         = 1'b1;
      res.matched_slot  = best_slot;
      res.matched_class = best_cls;
    end
    return res;
  endfunction

  // apply an accepted input transaction to the model
  task automatic take_item(input pam_pkg::in_item_t it);
    logic [pam_pkg::ADDR_W-1:0] a_hi;
    logic [pam_pkg::ADDR_W-1:0] a_lo;
    logic [1:0]                 kind;
    pam_pkg::out_item_t         res;
    a_hi = it.address_high;
    a_lo = it.address_low;
    // ipv4 keeps only the low 32 bits
    if (it.family == pam_pkg::FAM_IPV4) begin
      a_hi = '0;
      a_lo = {32'd0, a_lo[31:0]};
    end
    if (it.mode == pam_pkg::MODE_WRITE) begin
      n_writes++;
      kind = it.rule_kind;
      if (kind == pam_pkg::KIND_PREFIX &&
          it.prefix_length > ((it.family == pam_pkg::FAM_IPV6) ?
                              pam_pkg::PLEN_MAX_V6 : pam_pkg::PLEN_MAX_V4))
        kind = pam_pkg::KIND_EMPTY;
      if (int'(it.rule_slot) < MAX_RULES) begin
        rule_tbl[it.rule_slot].kind   = kind;
        rule_tbl[it.rule_slot].family = it.family;
        rule_tbl[it.rule_slot].plen   = it.prefix_length;
        rule_hi[it.rule_slot]         = a_hi;
        rule_lo[it.rule_slot]         = a_lo;
      end
    end else begin
      n_lookups++;
      res = best_rule_for_peer(it.family, a_hi, a_lo);
      if (res.found) n_class[res.matched_class]++;
      else n_miss++;
      expected_matches.push_back(res);
    end
  endtask

  // compare a result transaction against the oldest prediction
  task automatic check_result(input pam_pkg::out_item_t got);
    pam_pkg::out_item_t want;
    if (expected_matches.size() == 0) begin
      n_errors++;
      if (n_errors <= 10)
        $display("unexpected result transaction: found=%0d slot=%0d class=%0d",
                 got.found, got.matched_slot, got.matched_class);
    end else begin
      want = expected_matches.pop_front();
      if (got.found !== want.found || got.matched_slot !== want.matched_slot ||
          got.matched_class !== want.matched_class) begin
        n_errors++;
        if (n_errors <= 10)
          $display("expected found=%0d slot=%0d class=%0d, got found=%0d slot=%0d class=%0d",
                   want.found, want.matched_slot, want.matched_class,
                   got.found, got.matched_slot, got.matched_class);
      end
    end
  endtask

  // watch all three channels
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_count = '0;
      for (int i = 0; i < MAX_RULES; i++) begin
        rule_tbl[i].kind   = pam_pkg::KIND_EMPTY;
        rule_tbl[i].family = pam_pkg::FAM_IPV4;
        rule_tbl[i].plen   = '0;
        rule_hi[i]         = '0;
        rule_lo[i]         = '0;
      end
      expected_matches.delete();
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        rule_count = cfg_data_i;
        n_cfg++;
      end
      if (out_valid_i && !out_stall_i) check_result(out_data_i);
      if (in_valid_i && !in_stall_i) take_item(in_data_i);
      pending_o <= expected_matches.size();
      errors_o  <= n_errors;
    end
  end

  task automatic report_coverage();
    $display("covered %0d rule writes and %0d lookups over %0d rule_count settings",
             n_writes, n_lookups, n_cfg);
    $display("lookup answers: %0d host, %0d prefix, %0d any-client, %0d no match",
             n_class[pam_pkg::CLS_HOST], n_class[pam_pkg::CLS_PREFIX],
             n_class[pam_pkg::CLS_ANY], n_miss);
  endtask

endmodule

// ===== dv/tb_priority_address_rule_matcher_top.sv =====
`timescale 1ns / 1ps

module tb_priority_address_rule_matcher_top;

  localparam int TABLE_DEPTH = 64;
  localparam int ITEM_TARGET = 1150;
  localparam int CALM_FROM   = 1000;
  localparam int SCAN_TAIL   = TABLE_DEPTH + 8;
  localparam logic [pam_pkg::ADDR_W-1:0] ALL_ONES = {pam_pkg::ADDR_W{1'b1}};

  logic                      clk_i;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_stall_o;
  pam_pkg::in_item_t         in_data_i   = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  pam_pkg::out_item_t        out_data_o;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [pam_pkg::CFG_W-1:0] cfg_data_i  = '0;

  int pending;
  int mismatches;

  // stimulus shaping knobs
  int   gap_pct   = 0;
  int   stall_pct = 0;
  logic calm      = 1'b0;
  int   cur_count = 0;
  int   items     = 0;

  // what was written where, used only to aim lookups at real rules
  logic [1:0]                 shadow_kind [TABLE_DEPTH];
  logic                       shadow_fam  [TABLE_DEPTH];
  logic [pam_pkg::PLEN_W-1:0] shadow_plen [TABLE_DEPTH];
  logic [127:0]               shadow_addr [TABLE_DEPTH];

  priority_address_rule_matcher_top #(
    .MAX_RULES (TABLE_DEPTH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  rule_match_checker #(
    .MAX_RULES (TABLE_DEPTH)
  ) chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .pending_o   (pending),
    .errors_o    (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // hard stop if the block hangs
  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

  // receiver back-pressure in random bursts
  initial begin
    forever begin
      @(posedge clk_i);
      if (!calm && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic logic [pam_pkg::ADDR_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // offer one transaction, optionally after a gap, and wait for acceptance
  task automatic push_item(input pam_pkg::in_item_t it);
    if (!calm && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items++;
  endtask

  task automatic send_rule(input logic [pam_pkg::SLOT_W-1:0] slot,
                           input logic [1:0]                 kind,
                           input logic                       fam,
                           input logic [pam_pkg::PLEN_W-1:0] plen,
                           input logic [pam_pkg::ADDR_W-1:0] a_hi,
                           input logic [pam_pkg::ADDR_W-1:0] a_lo);
    pam_pkg::in_item_t it;
    it.mode          = pam_pkg::MODE_WRITE;
    it.rule_slot     = slot;
    it.rule_kind     = kind;
    it.family        = fam;
    it.prefix_length = plen;
    it.address_high  = a_hi;
    it.address_low   = a_lo;
    shadow_kind[slot] = (kind == pam_pkg::KIND_PREFIX &&
                         plen > ((fam == pam_pkg::FAM_IPV6) ?
                                 pam_pkg::PLEN_MAX_V6 : pam_pkg::PLEN_MAX_V4)) ?
                        pam_pkg::KIND_EMPTY : kind;
    shadow_fam[slot]  = fam;
    shadow_plen[slot] = plen;
    shadow_addr[slot] = {a_hi, a_lo};
    push_item(it);
  endtask

  // lookup with the unused fields left random
  task automatic send_lookup(input logic fam, input logic [pam_pkg::ADDR_W-1:0] a_hi,
                             input logic [pam_pkg::ADDR_W-1:0] a_lo);
    pam_pkg::in_item_t it;
    it.mode          = pam_pkg::MODE_LOOKUP;
    it.rule_slot     = pam_pkg::SLOT_W'($urandom);
    it.rule_kind     = 2'($urandom);
    it.family        = fam;
    it.prefix_length = pam_pkg::PLEN_W'($urandom);
    it.address_high  = a_hi;
    it.address_low   = a_lo;
    push_item(it);
  endtask

  // hold the sender until every lookup has answered and the block is quiet
  task automatic wait_for_results(input int tail);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  task automatic set_rule_count(input int value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= pam_pkg::CFG_W'(value);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_count = value;
  endtask

  // one random transaction, mostly rules inside the scanned window and
  // lookups aimed at them
  task automatic random_item();
    int                         lim;
    int                         roll;
    int                         s;
    int                         w;
    logic                       fam;
    logic [1:0]                 kind;
    logic [pam_pkg::PLEN_W-1:0] plen;
    logic [127:0]               peer;
    logic [127:0]               noise;
    logic [127:0]               keep;
    lim  = (cur_count == 0) ? 1 : ((cur_count > TABLE_DEPTH) ? TABLE_DEPTH : cur_count);
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      s    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, TABLE_DEPTH - 1) :
                                           $urandom_range(0, lim - 1);
      roll = $urandom_range(0, 99);
      kind = (roll < 35) ? pam_pkg::KIND_HOST : (roll < 85) ? pam_pkg::KIND_PREFIX :
             (roll < 93) ? pam_pkg::KIND_EMPTY : pam_pkg::KIND_ANY;
      fam  = 1'($urandom);
      if (kind == pam_pkg::KIND_PREFIX && $urandom_range(0, 9) != 0)
        plen = (fam == pam_pkg::FAM_IPV6) ? pam_pkg::PLEN_W'($urandom_range(0, 128)) :
                                            pam_pkg::PLEN_W'($urandom_range(0, 32));
      else
        plen = pam_pkg::PLEN_W'($urandom_range(0, 255));
      send_rule(pam_pkg::SLOT_W'(s), kind, fam, plen, rand64(), rand64());
    end else begin
      s = $urandom_range(0, lim - 1);
      if (roll < 85 && (shadow_kind[s] == pam_pkg::KIND_HOST ||
                        shadow_kind[s] == pam_pkg::KIND_PREFIX)) begin
        fam   = shadow_fam[s];
        peer  = shadow_addr[s];
        noise = {rand64(), rand64()};
        w     = (fam == pam_pkg::FAM_IPV6) ? 128 : 32;
        // randomise the bits a prefix leaves free
        if (shadow_kind[s] == pam_pkg::KIND_PREFIX) begin
          keep = (shadow_plen[s] == 0) ? 128'd0 :
                 ({128{1'b1}} << (128 - shadow_plen[s]));
          if (w == 32) keep = keep >> 96;
          peer = (peer & keep) | (noise & ~keep);
        end
        // now and then break the match
        if ($urandom_range(0, 7) == 0) peer[$urandom_range(0, w - 1)] ^= 1'b1;
        // ipv4 ignores everything above bit 31
        if (fam == pam_pkg::FAM_IPV4) peer[127:32] = {rand64(), noise[31:0]};
      end else begin
        fam  = 1'($urandom);
        peer = {rand64(), rand64()};
      end
      send_lookup(fam, peer[127:64], peer[63:0]);
    end
  endtask

  initial begin
    int len;
    int phase;
    for (int i = 0; i < TABLE_DEPTH; i++) shadow_kind[i] = pam_pkg::KIND_EMPTY;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: families, prefix limits, class order, count extremes
    set_rule_count(16);
    send_lookup(pam_pkg::FAM_IPV4, rand64(), 64'd0);
    send_rule(6'd0, pam_pkg::KIND_HOST, pam_pkg::FAM_IPV4, 8'hFF, ALL_ONES,
              64'hA5A5_A5A5_1234_5678);
    send_lookup(pam_pkg::FAM_IPV4, 64'h0123_4567_89AB_CDEF, 64'h0000_0000_1234_5678);
    send_lookup(pam_pkg::FAM_IPV6, 64'd0, 64'h0000_0000_1234_5678);
    send_rule(6'd1, pam_pkg::KIND_PREFIX, pam_pkg::FAM_IPV4, 8'd33, 64'd0, 64'd0);
    send_rule(6'd2, pam_pkg::KIND_PREFIX, pam_pkg::FAM_IPV6, 8'd129, 64'd0, 64'd0);
    send_lookup(pam_pkg::FAM_IPV4, 64'd0, 64'd0);
    send_rule(6'd3, pam_pkg::KIND_PREFIX, pam_pkg::FAM_IPV6, 8'd0, ALL_ONES, ALL_ONES);
    send_lookup(pam_pkg::FAM_IPV6, rand64(), rand64());
    send_rule(6'd4, pam_pkg::KIND_PREFIX, pam_pkg::FAM_IPV4, 8'd32, 64'd0, 64'hFFFF_FFFF);
    send_lookup(pam_pkg::FAM_IPV4, 64'd0, 64'hFFFF_FFFF);
    send_rule(6'd5, pam_pkg::KIND_PREFIX, pam_pkg::FAM_IPV6, 8'd128, ALL_ONES, ALL_ONES);
    send_rule(6'd6, pam_pkg::KIND_HOST, pam_pkg::FAM_IPV6, 8'd0, ALL_ONES, ALL_ONES);
    send_lookup(pam_pkg::FAM_IPV6, ALL_ONES, ALL_ONES);
    send_rule(6'd7, pam_pkg::KIND_ANY, pam_pkg::FAM_IPV6, 8'hFF, rand64(), rand64());
    send_lookup(pam_pkg::FAM_IPV4, 64'd0, 64'd0);
    send_rule(6'd15, pam_pkg::KIND_ANY, pam_pkg::FAM_IPV4, 8'd0, 64'd0, 64'd0);
    send_rule(6'd63, pam_pkg::KIND_HOST, pam_pkg::FAM_IPV4, 8'd0, 64'd0, 64'd0);
    send_lookup(pam_pkg::FAM_IPV4, 64'd0, 64'd0);
    send_rule(6'd0, pam_pkg::KIND_EMPTY, pam_pkg::FAM_IPV6, 8'hFF, ALL_ONES, ALL_ONES);
    send_lookup(pam_pkg::FAM_IPV4, 64'd0, 64'h1234_5678);
    wait_for_results(4);
    set_rule_count(127);
    send_lookup(pam_pkg::FAM_IPV4, 64'd0, 64'd0);
    wait_for_results(4);
    set_rule_count(TABLE_DEPTH);
    send_lookup(pam_pkg::FAM_IPV4, 64'd0, 64'd0);
    wait_for_results(4);
    set_rule_count(0);
    send_lookup(pam_pkg::FAM_IPV6, ALL_ONES, ALL_ONES);

    // random phases, each under its own rule_count and idling mix
    phase = 0;
    while (items < ITEM_TARGET) begin
      wait_for_results(4);
      case (phase)
        0:       set_rule_count(TABLE_DEPTH);
        1:       set_rule_count(127);
        2:       set_rule_count(1);
        3:       set_rule_count(0);
        4:       set_rule_count(TABLE_DEPTH + 1);
        default: set_rule_count(($urandom_range(0, 9) == 0) ? $urandom_range(65, 127) :
                                                              $urandom_range(1, 64));
      endcase
      gap_pct   = (phase % 3 == 0) ? 0 : $urandom_range(5, 40);
      stall_pct = (phase % 4 == 1) ? 0 : $urandom_range(2, 25);
      len       = (phase == 3) ? 20 : $urandom_range(40, 110);
      for (int k = 0; k < len && items < ITEM_TARGET; k++) begin
        if (items >= CALM_FROM) calm = 1'b1;
        // in phase 6 the sender holds mid-phase until the block has answered everything
        if (phase == 6 && k == len / 2) wait_for_results(4);
        random_item();
      end
      phase++;
    end

    wait_for_results(SCAN_TAIL);
    chk.report_coverage();
    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
